// ===== rtl/conv2d_3x3_stream_top_assert.svh =====
// Assertion macros shared by the 3x3 convolution RTL
`ifndef CONV2D_3X3_STREAM_TOP_ASSERT_SVH
`define CONV2D_3X3_STREAM_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define C2D_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("c2d: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define C2D_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("c2d: next-cycle check failed");

`endif

// ===== rtl/c2d_pkg.sv =====
// Types and constants of the 3x3 streaming convolution
`default_nettype none

package c2d_pkg;

    localparam int PIXEL_BITS      = 8;
    localparam int COEFF_FRAC_BITS = 8;
    localparam int COEFF_BITS      = COEFF_FRAC_BITS + 4;
    localparam int TAPS            = 3;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 36;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int ROW_W        = 13;
    localparam int HEIGHT_LIMIT = 4096;

    localparam int OUT_W  = 16;
    localparam int PROD_W = COEFF_BITS + PIXEL_BITS + 1;
    localparam int SUM_W  = PROD_W + 4;
    localparam int QUOT_W = SUM_W - COEFF_FRAC_BITS;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_MID    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_BOTTOM = 3'd4;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET     = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET    = 13'd1024;
    localparam logic [CFG_DATA_W-1:0]   COEFF_MID_RESET = 36'h000100000; // centre = 1.0

    localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

    typedef logic [PIXEL_BITS-1:0] t_pixel;
    typedef t_pixel [TAPS-1:0] t_pix_col;            // [0] top, [1] mid, [2] bottom
    typedef logic [CFG_DATA_W-1:0] t_coeff_row;
    typedef t_coeff_row [TAPS-1:0] t_coeff_rows;     // [0] top row

    typedef struct packed {
        t_pixel pixel_value;
        logic   flush;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered_value;
        logic                    frame_last;
    } t_out_item;

    // decoded item, counter stage to window stage
    typedef struct packed {
        logic   emit;
        logic   last;
        logic   shift;
        logic   lclamp;
        logic   right_new;
        logic   top_clamp;
        logic   drain;
        t_pixel pixel;
    } t_s1_ctl;

    // operands, window stage to multiply stage
    typedef struct packed {
        logic                valid;
        logic                last;
        t_pix_col [TAPS-1:0] pix;    // [0] left, [1] centre, [2] right
    } t_ops;

endpackage

`default_nettype wire

// ===== rtl/c2d_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module c2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/c2d_ctrl.sv =====
// Position counters, frame/drain decode and input handshake
`default_nettype none
`include "conv2d_3x3_stream_top_assert.svh"

module c2d_ctrl
    import c2d_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  t_in_item                i_in_item,
    output logic                    o_in_ready,
    input  logic [WIDTH_REG_W-1:0]  i_image_width,
    input  logic [HEIGHT_REG_W-1:0] i_image_height,
    input  logic                    i_s1_free,
    output logic                    o_load,
    output t_s1_ctl                 o_s1_ctl,
    output logic [COL_W-1:0]        o_rd_addr
);

    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WID_W > WIDTH_REG_W) ? WID_W : WIDTH_REG_W;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] col_inc;
    logic [ROW_W-1:0] h_eff;
    logic [ROW_W-1:0] h_plus1;
    logic [COL_W-1:0] col1, col2;
    logic [ROW_W-1:0] row1, row2;
    logic             wrap_in;
    logic             clr;
    logic             drain;
    logic             skip;
    logic             right_edge;
    logic             last;
    logic             inner;
    logic             width_one;
    logic             accept;

    always_comb begin
        if (i_image_width == '0) begin
            w_eff = CMP_W'(1);
        end else if (CMP_W'(i_image_width) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = CMP_W'(i_image_width);
        end

        if (i_image_height == '0) begin
            h_eff = ROW_W'(1);
        end else if (ROW_W'(i_image_height) > ROW_W'(HEIGHT_LIMIT)) begin
            h_eff = ROW_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = ROW_W'(i_image_height);
        end
        h_plus1 = h_eff + ROW_W'(1);

        // a narrower width written mid frame pushes the column to the next row
        wrap_in = CMP_W'(r_col) >= w_eff;
        col1    = wrap_in ? '0 : r_col;
        row1    = wrap_in ? r_row + ROW_W'(1) : r_row;

        // position past the end of the drain: start a new frame
        clr  = (row1 > h_plus1) || ((row1 == h_plus1) && (col1 != '0));
        col2 = clr ? '0 : col1;
        row2 = clr ? '0 : row1;

        drain      = row2 >= h_eff;
        skip       = !drain && i_in_item.flush;
        right_edge = (col2 == '0) && (row2 >= ROW_W'(2));
        last       = right_edge && (row2 == h_plus1);
        inner      = (col2 != '0) && (row2 != '0);
        width_one  = w_eff == CMP_W'(1);
        col_inc    = CMP_W'(col2) + CMP_W'(1);

        if (skip) begin
            n_col = col2;
            n_row = row2;
        end else if (last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = row2 + ROW_W'(1);
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = row2;
        end

        o_s1_ctl.emit      = right_edge || inner;
        o_s1_ctl.last      = last;
        o_s1_ctl.shift     = !last;
        o_s1_ctl.lclamp    = right_edge ? width_one : (col2 == COL_W'(1));
        o_s1_ctl.right_new = !right_edge;
        o_s1_ctl.top_clamp = row2 == ROW_W'(1);
        o_s1_ctl.drain     = drain;
        o_s1_ctl.pixel     = i_in_item.pixel_value;
    end

    assign o_in_ready = i_s1_free;
    assign accept     = i_in_valid && i_s1_free;
    assign o_load     = accept && !skip;
    assign o_rd_addr  = col2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    `C2D_ASSERT_NXT(a_last_restarts_frame, accept && o_load && last, (r_col == '0) && (r_row == '0))

endmodule

`default_nettype wire

// ===== rtl/c2d_window.sv =====
// Row stores, 3x3 window and operand register
`default_nettype none
`include "conv2d_3x3_stream_top_assert.svh"

module c2d_window
    import c2d_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_s1_ctl          i_s1_ctl,
    input  logic [COL_W-1:0] i_rd_addr,
    input  logic             i_out_free,
    output logic             o_s1_free,
    output t_ops             o_ops
);

    logic                r_s1_valid;
    t_s1_ctl             r_s1_ctl;
    logic [COL_W-1:0]    r_s1_col;
    logic                r_fwd;
    t_pixel              r_fwd_a;
    t_pixel              r_fwd_b;
    t_pix_col            r_win [TAPS];
    logic                r_ops_valid;
    logic                r_ops_last;
    t_pix_col [TAPS-1:0] r_ops_pix;

    t_pixel              ram_a_q;
    t_pixel              ram_b_q;
    t_pixel              a_val;
    t_pixel              b_val;
    t_pix_col            new_col;
    t_pix_col [TAPS-1:0] ops_pix;
    logic                s2_free;
    logic                s1_move;
    logic                wr_en;

    // row store A holds the previous row, B the row before it
    c2d_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_a (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_col),
        .i_wdata (new_col[2]),
        .i_re    (i_load),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_a_q)
    );

    c2d_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_b (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_col),
        .i_wdata (new_col[1]),
        .i_re    (i_load),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_b_q)
    );

    always_comb begin
        // write and read of one column in the same cycle: take the written data
        a_val = r_fwd ? r_fwd_a : ram_a_q;
        b_val = r_fwd ? r_fwd_b : ram_b_q;

        new_col[1] = a_val;
        new_col[0] = r_s1_ctl.top_clamp ? a_val : b_val;
        new_col[2] = r_s1_ctl.drain ? a_val : r_s1_ctl.pixel;

        s2_free   = !r_ops_valid || i_out_free;
        s1_move   = r_s1_valid && (!r_s1_ctl.emit || s2_free);
        o_s1_free = !r_s1_valid || s1_move;
        wr_en     = s1_move && r_s1_ctl.shift;

        ops_pix[0] = r_s1_ctl.lclamp ? r_win[2] : r_win[1];
        ops_pix[1] = r_win[2];
        ops_pix[2] = r_s1_ctl.right_new ? new_col : r_win[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_ops_valid <= 1'b0;
            r_win[0]    <= '0;
            r_win[1]    <= '0;
            r_win[2]    <= '0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= wr_en && (r_s1_col == i_rd_addr);
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (wr_en) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= new_col;
            end

            if (s1_move && r_s1_ctl.emit) begin
                r_ops_valid <= 1'b1;
            end else if (i_out_free) begin
                r_ops_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_ctl <= i_s1_ctl;
            r_s1_col <= i_rd_addr;
            r_fwd_a  <= new_col[2];
            r_fwd_b  <= new_col[1];
        end
        if (s1_move && r_s1_ctl.emit) begin
            r_ops_last <= r_s1_ctl.last;
            r_ops_pix  <= ops_pix;
        end
    end

    assign o_ops = '{valid: r_ops_valid, last: r_ops_last, pix: r_ops_pix};

    `C2D_ASSERT_IMP(a_load_only_when_free, i_load, o_s1_free)
    `C2D_ASSERT_NXT(a_ops_held_on_stall, r_ops_valid && !i_out_free, r_ops_valid && $stable(r_ops_pix))

endmodule

`default_nettype wire

// ===== rtl/c2d_mac.sv =====
// Nine-tap multiply-accumulate, floor shift, saturation and result register
`default_nettype none
`include "conv2d_3x3_stream_top_assert.svh"

module c2d_mac
    import c2d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ops        i_ops,
    input  t_coeff_rows i_coeff_rows,
    input  logic        i_out_ready,
    output logic        o_out_free,
    output logic        o_out_valid,
    output t_out_item   o_out_item
);

    logic signed [COEFF_BITS-1:0] coef  [TAPS][TAPS];
    logic signed [PIXEL_BITS:0]   pix_s [TAPS][TAPS];
    logic signed [PROD_W-1:0]     prod  [TAPS][TAPS];
    logic signed [SUM_W-1:0]      row_sum [TAPS];
    logic signed [SUM_W-1:0]      sum;
    logic signed [QUOT_W-1:0]     quot;
    logic signed [OUT_W-1:0]      sat;

    logic                         r_out_valid;
    t_out_item                    r_out_item;

    always_comb begin
        // coef[j][k]: column j (left..right), kernel row k (top..bottom)
        for (int j = 0; j < TAPS; j++) begin
            for (int k = 0; k < TAPS; k++) begin
                coef[j][k]  = signed'(i_coeff_rows[k][j*COEFF_BITS +: COEFF_BITS]);
                pix_s[j][k] = signed'({1'b0, i_ops.pix[j][k]});
                prod[j][k]  = coef[j][k] * pix_s[j][k];
            end
        end
        for (int k = 0; k < TAPS; k++) begin
            row_sum[k] = SUM_W'(prod[0][k]) + SUM_W'(prod[1][k]) + SUM_W'(prod[2][k]);
        end
        sum = row_sum[0] + row_sum[1] + row_sum[2];

        // arithmetic shift rounds toward minus infinity
        quot = QUOT_W'(sum >>> COEFF_FRAC_BITS);

        if ((quot[QUOT_W-1:OUT_W-1] == '0) || (quot[QUOT_W-1:OUT_W-1] == '1)) begin
            sat = quot[OUT_W-1:0];
        end else begin
            sat = quot[QUOT_W-1] ? OUT_MIN : OUT_MAX;
        end
    end

    assign o_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ops.valid && o_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ops.valid && o_out_free) begin
            r_out_item.filtered_value <= sat;
            r_out_item.frame_last     <= i_ops.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `C2D_ASSERT_NXT(a_operands_reach_output, i_ops.valid && o_out_free, r_out_valid)

endmodule

`default_nettype wire

// ===== rtl/conv2d_3x3_stream_top.sv =====
// From the edge that accepts the item causing it, a result passes the operand register and then the result register.
// Throughput: one item per cycle while the output is not held; stages are counter decode + row-store read,
// window update, and the nine-tap multiply-accumulate into the result register.
// Reset (synchronous, active low) clears counters, window and valid flags and loads
// the register reset values; the row stores are not cleared and need no clearing pass.
`default_nettype none

module conv2d_3x3_stream_top
    import c2d_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [WIDTH_REG_W-1:0]  r_image_width;
    logic [HEIGHT_REG_W-1:0] r_image_height;
    t_coeff_rows             r_coeff_rows;

    logic                    s1_free;
    logic                    load;
    t_s1_ctl                 s1_ctl;
    logic [COL_W-1:0]        rd_addr;
    t_ops                    ops;
    logic                    out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= WIDTH_RESET;
            r_image_height  <= HEIGHT_RESET;
            r_coeff_rows[0] <= '0;
            r_coeff_rows[1] <= COEFF_MID_RESET;
            r_coeff_rows[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width   <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height  <= i_cfg_data[HEIGHT_REG_W-1:0];
                CFG_COEFF_TOP:    r_coeff_rows[0] <= i_cfg_data;
                CFG_COEFF_MID:    r_coeff_rows[1] <= i_cfg_data;
                CFG_COEFF_BOTTOM: r_coeff_rows[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    c2d_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_item      (i_in_item),
        .o_in_ready     (o_in_ready),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_s1_free      (s1_free),
        .o_load         (load),
        .o_s1_ctl       (s1_ctl),
        .o_rd_addr      (rd_addr)
    );

    c2d_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_s1_ctl   (s1_ctl),
        .i_rd_addr  (rd_addr),
        .i_out_free (out_free),
        .o_s1_free  (s1_free),
        .o_ops      (ops)
    );

    c2d_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ops        (ops),
        .i_coeff_rows (r_coeff_rows),
        .i_out_ready  (i_out_ready),
        .o_out_free   (out_free),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item)
    );

endmodule

`default_nettype wire

// ===== sim/tb_conv2d_3x3_stream_top.sv =====
// Self-checking testbench for the streaming 3x3 convolution top level
`timescale 1ns / 1ps

module tb_conv2d_3x3_stream_top;
    import c2d_pkg::*;

    localparam int LINE_MAX     = 1024;
    localparam int RANDOM_ITEMS = 1250;
    localparam int RUN_LIMIT    = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 8;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    conv2d_3x3_stream_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state: own copy of the registers, line stores, window and position
    logic [WIDTH_REG_W-1:0]  cfg_width  = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] cfg_height = HEIGHT_RESET;
    logic [CFG_DATA_W-1:0]   kernel_row [TAPS] = '{'0, COEFF_MID_RESET, '0};
    bit [PIXEL_BITS-1:0]     last_line  [LINE_MAX];
    bit [PIXEL_BITS-1:0]     older_line [LINE_MAX];
    bit [PIXEL_BITS-1:0]     win [9];   // column-major, column 0 oldest
    int unsigned             pix_col = 0;
    int unsigned             pix_row = 0;

    t_in_item  pixel_feed [$];
    t_out_item filtered_due [$];

    int cycle_count       = 0;
    int items_accepted    = 0;
    int flushes_accepted  = 0;
    int results_seen      = 0;
    int mismatches        = 0;
    int frames_done       = 0;
    int hold_at           = -1;
    int hold_left         = 0;
    int send_wait         = 0;
    int recv_wait         = 0;
    bit send_idle_on      = 1'b0;
    bit recv_idle_on      = 1'b0;

    function automatic int unsigned cols_eff();
        if (cfg_width == 0) return 1;
        if (cfg_width > LINE_MAX) return LINE_MAX;
        return 32'(cfg_width);
    endfunction

    function automatic int unsigned rows_eff();
        if (cfg_height == 0) return 1;
        if (cfg_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return 32'(cfg_height);
    endfunction

    function automatic int tap(input int unsigned r, input int unsigned c);
        logic [COEFF_BITS-1:0] raw;
        raw = kernel_row[r][c*COEFF_BITS +: COEFF_BITS];
        return int'($signed(raw));
    endfunction

    // lb, cb, rb: window index of the top pixel of the left, centre and right column
    function automatic t_out_item filter_at(input int lb, input int cb, input int rb,
                                            input logic last);
        int        acc;
        int        q;
        t_out_item res;
        acc = 0;
        for (int k = 0; k < TAPS; k++)
            acc += tap(k, 0) * int'(win[lb+k]) + tap(k, 1) * int'(win[cb+k])
                 + tap(k, 2) * int'(win[rb+k]);
        q = acc >>> COEFF_FRAC_BITS;   // floor
        if (q > int'(OUT_MAX)) q = int'(OUT_MAX);
        else if (q < int'(OUT_MIN)) q = int'(OUT_MIN);
        res.filtered_value = q[OUT_W-1:0];
        res.frame_last     = last;
        return res;
    endfunction

    function automatic void convolve_item(input t_in_item it);
        int unsigned w, h, r, c;
        t_pixel      pix, above, centre, below;
        logic        drain, last;
        w = cols_eff();
        h = rows_eff();
        if (pix_col >= w) begin
            pix_col = 0;
            pix_row++;
        end
        if (pix_row > h + 1 || (pix_row == h + 1 && pix_col != 0)) begin
            pix_col = 0;
            pix_row = 0;
        end
        drain = (pix_row >= h);
        if (!drain && it.flush) return;   // flush in mid frame is ignored
        r   = pix_row;
        c   = pix_col;
        pix = drain ? '0 : it.pixel_value;

        // right-hand output of the row before last
        if (c == 0 && r >= 2) begin
            last = (r == h + 1);
            filtered_due.push_back(filter_at((w == 1) ? 6 : 3, 6, 6, last));
            if (last) begin
                pix_col = 0;
                pix_row = 0;
                return;
            end
        end

        centre = last_line[c];
        above  = (r == 1) ? centre : older_line[c];
        below  = drain ? centre : pix;
        older_line[c] = centre;
        last_line[c]  = below;
        for (int k = 0; k < 6; k++) win[k] = win[k+3];
        win[6] = above;
        win[7] = centre;
        win[8] = below;

        if (c >= 1 && r >= 1)
            filtered_due.push_back(filter_at((c == 1) ? 3 : 0, 3, 6, 1'b0));

        pix_col++;
        if (pix_col >= w) begin
            pix_col = 0;
            pix_row++;
        end
    endfunction

    // sender: offers queued items, random gap after each
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (in_valid && in_ready) begin
                convolve_item(in_item);
                items_accepted++;
                if (in_item.flush) flushes_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    in_valid <= 1'b0;
                end else if (pixel_feed.size() > 0) begin
                    in_item  <= pixel_feed.pop_front();
                    in_valid <= 1'b1;
                    send_wait = send_idle_on ? $urandom_range(0, 9) : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result, random stalls plus the occasional long hold
    always @(posedge clk) begin : receiver
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (filtered_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value %0d last %0b",
                                 $signed(out_item.filtered_value), out_item.frame_last);
                end else begin
                    want = filtered_due.pop_front();
                    if (out_item.filtered_value !== want.filtered_value
                        || out_item.frame_last !== want.frame_last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected value %0d last %0b, got %0d last %0b",
                                     results_seen, $signed(want.filtered_value),
                                     want.frame_last, $signed(out_item.filtered_value),
                                     out_item.frame_last);
                    end
                end
                results_seen++;
                if (results_seen == hold_at) hold_left = HOLD_CYCLES;
                recv_wait = recv_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) cycle_count++;

    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  cfg_width  = val[WIDTH_REG_W-1:0];
            CFG_IMAGE_HEIGHT: cfg_height = val[HEIGHT_REG_W-1:0];
            CFG_COEFF_TOP:    kernel_row[0] = val;
            CFG_COEFF_MID:    kernel_row[1] = val;
            CFG_COEFF_BOTTOM: kernel_row[2] = val;
            default: ;
        endcase
    endtask

    function automatic void feed(input t_pixel p, input logic fl);
        t_in_item it;
        it.pixel_value = p;
        it.flush       = fl;
        pixel_feed.push_back(it);
    endfunction

    function automatic t_pixel any_pixel();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return t_pixel'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] any_kernel_row();
        return CFG_DATA_W'({$urandom_range(0, 15), $urandom()});
    endfunction

    // pick idling for this frame, then wait until every item is in and every result out
    task automatic await_frame_end();
        send_idle_on = 1'($urandom_range(0, 1));
        recv_idle_on = 1'($urandom_range(0, 1));
        while (pixel_feed.size() != 0 || in_valid || filtered_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        frames_done++;
    endtask

    // one frame at the current size, flush noise mixed in, drain items at the end
    task automatic random_frame(input int unsigned noise_pct, output int unsigned counted);
        int unsigned w, h;
        w = cols_eff();
        h = rows_eff();
        @(negedge clk);
        for (int unsigned i = 0; i < w * h; i++) begin
            while ($urandom_range(0, 99) < noise_pct) feed(any_pixel(), 1'b1);
            feed(any_pixel(), 1'b0);
        end
        for (int unsigned i = 0; i <= w; i++) feed(any_pixel(), 1'($urandom_range(0, 1)));
        counted = w * h + w + 1;
        await_frame_end();
    endtask

    initial begin : stimulus
        int unsigned counted;
        int unsigned random_items;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // 3x2 with the reset kernel (identity); flush before the first pixel and
        // in mid frame, pixels offered during the drain
        write_reg(CFG_IMAGE_WIDTH, 3);
        write_reg(CFG_IMAGE_HEIGHT, 2);
        @(negedge clk);
        feed(8'd77, 1'b1);
        feed(8'd0, 1'b0);   feed(8'd255, 1'b0); feed(8'd17, 1'b0);
        feed(8'd0, 1'b1);
        feed(8'd200, 1'b0); feed(8'd1, 1'b0);   feed(8'd128, 1'b0);
        feed(8'd255, 1'b0); feed(8'd0, 1'b1);   feed(8'd0, 1'b1);   feed(8'd0, 1'b0);
        await_frame_end();

        // zero size registers clamp to 1x1; most negative kernel, floor of a negative sum
        write_reg(CFG_IMAGE_WIDTH, 0);
        write_reg(CFG_IMAGE_HEIGHT, 0);
        write_reg(CFG_COEFF_TOP, 36'h800800800);
        write_reg(CFG_COEFF_MID, 36'h800800800);
        write_reg(CFG_COEFF_BOTTOM, 36'h800800801);
        @(negedge clk);
        feed(8'd255, 1'b0); feed(8'd3, 1'b1); feed(8'd9, 1'b0);
        await_frame_end();

        // most positive kernel on full-scale pixels
        write_reg(CFG_IMAGE_WIDTH, 2);
        write_reg(CFG_IMAGE_HEIGHT, 3);
        for (int k = 0; k < TAPS; k++)
            write_reg(CFG_IDX_W'(CFG_COEFF_TOP + k), 36'h7FF7FF7FF);
        @(negedge clk);
        repeat (6) feed(8'd255, 1'b0);
        feed(8'd0, 1'b1); feed(8'd255, 1'b0); feed(8'd0, 1'b1);
        await_frame_end();

        // mostly small frames, sizes and kernel rows changed between frames
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
                          $urandom_range(13, 80) : $urandom_range(1, 12)));
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'((cols_eff() > 12) ?
                          $urandom_range(1, 3) : $urandom_range(1, 8)));
            for (int k = 0; k < TAPS; k++)
                if ($urandom_range(0, 1))
                    write_reg(CFG_IDX_W'(CFG_COEFF_TOP + k), any_kernel_row());
            random_frame($urandom_range(0, 15), counted);
            random_items += counted;
        end

        // wider frame with a long output hold part way through, so the input stalls
        write_reg(CFG_IMAGE_WIDTH, 48);
        write_reg(CFG_IMAGE_HEIGHT, 4);
        for (int k = 0; k < TAPS; k++)
            write_reg(CFG_IDX_W'(CFG_COEFF_TOP + k), any_kernel_row());
        hold_at = results_seen + 50;
        random_frame(5, counted);

        repeat (10) @(negedge clk);
        $display("Ran %0d frames, %0d items in (%0d flush), %0d results checked, %0d mismatches",
                 frames_done, items_accepted, flushes_accepted, results_seen, mismatches);
        $display("Frames 1x1 to 80 wide or 8 high, extreme and random kernels, one long hold");
        if (filtered_due.size() != 0)
            $display("%0d expected results never arrived", filtered_due.size());
        if (mismatches == 0 && filtered_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
